@@ design/prac_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, pipeline types and the arctangent table for the point rotation unit.
package prac_pkg;

  localparam int CoordWidth   = 16;
  localparam int CordicStages = 14;

  localparam int AngW    = 16;
  localparam int PosW    = 15;
  localparam int RatioW  = 16;
  localparam int CenterW = PosW + 1;
  localparam int DiffW   = CenterW + 1;
  localparam int AProdW  = AngW + RatioW;
  localparam int EffW    = AProdW - 14;
  localparam int CsW     = 33;
  localparam int ZW      = 25;
  localparam int StageW  = 5;
  localparam int ProdW   = DiffW + CsW;
  localparam int RotW    = ProdW + 1 - 30;
  localparam int SumW    = (RotW + 1 > CoordWidth + 1) ? RotW + 1 : CoordWidth + 1;
  localparam int Latency = CordicStages + 5;

  localparam int UnitsFull    = 23040;
  localparam int UnitsHalf    = 11520;
  localparam int UnitsQuarter = 5760;
  localparam int WrapSteps    = 5;
  localparam int WrapBias     = 3 * UnitsFull;
  localparam int GainQ30      = 652032874;

  localparam logic signed [CoordWidth-1:0] CoordMax = {1'b0, {(CoordWidth - 1){1'b1}}};
  localparam logic signed [CoordWidth-1:0] CoordMin = {1'b1, {(CoordWidth - 1){1'b0}}};

  localparam logic [1:0] RegAngle   = 2'd0;
  localparam logic [1:0] RegCenterX = 2'd1;
  localparam logic [1:0] RegCenterY = 2'd2;

  typedef struct packed {
    logic signed [CenterW-1:0] cx;
    logic signed [CenterW-1:0] cy;
    logic signed [DiffW-1:0]   dx;
    logic signed [DiffW-1:0]   dy;
  } geom_t;

  typedef struct packed {
    logic                  valid;
    logic                  neg;
    logic signed [CsW-1:0] x;
    logic signed [CsW-1:0] y;
    logic signed [ZW-1:0]  z;
    geom_t                 geom;
  } rot_t;

  function automatic logic signed [ZW-1:0] atan_q16(input logic [StageW-1:0] idx);
    logic signed [ZW-1:0] r;
    case (idx)
      5'd0:    r = 25'sd2949120;
      5'd1:    r = 25'sd1740967;
      5'd2:    r = 25'sd919879;
      5'd3:    r = 25'sd466945;
      5'd4:    r = 25'sd234379;
      5'd5:    r = 25'sd117304;
      5'd6:    r = 25'sd58666;
      5'd7:    r = 25'sd29335;
      5'd8:    r = 25'sd14668;
      5'd9:    r = 25'sd7334;
      5'd10:   r = 25'sd3667;
      5'd11:   r = 25'sd1833;
      5'd12:   r = 25'sd917;
      5'd13:   r = 25'sd458;
      5'd14:   r = 25'sd229;
      5'd15:   r = 25'sd115;
      5'd16:   r = 25'sd57;
      5'd17:   r = 25'sd29;
      5'd18:   r = 25'sd14;
      5'd19:   r = 25'sd7;
      5'd20:   r = 25'sd4;
      5'd21:   r = 25'sd2;
      5'd22:   r = 25'sd1;
      default: r = 25'sd0;
    endcase
    return r;
  endfunction

endpackage

@@ design/prac_angle.sv @@
`timescale 1ns / 1ps
// Front end: angle scaling, wrap and quadrant fold, center and offset arithmetic.
module prac_angle (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic signed [prac_pkg::AngW-1:0]      angle_deg,
  input  logic signed [prac_pkg::PosW-1:0]      center_x_base,
  input  logic signed [prac_pkg::PosW-1:0]      center_y_base,
  input  logic signed [prac_pkg::PosW-1:0]      point_x,
  input  logic signed [prac_pkg::PosW-1:0]      point_y,
  input  logic signed [prac_pkg::RatioW-1:0]    angle_ratio,
  input  logic signed [prac_pkg::PosW-1:0]      offset_x,
  input  logic signed [prac_pkg::PosW-1:0]      offset_y,
  output prac_pkg::rot_t                        rot_out
);

  logic                                   s1_valid;
  logic signed [prac_pkg::AProdW-1:0]     s1_prod;
  prac_pkg::geom_t                        s1_geom;
  prac_pkg::geom_t                        geom_next;

  logic signed [prac_pkg::AProdW-1:0]     rnd;
  logic signed [prac_pkg::EffW-1:0]       eff;
  logic [prac_pkg::EffW-1:0]              ubias;
  logic [prac_pkg::EffW-1:0]              wrapped;
  logic                                   s2_valid;
  logic signed [prac_pkg::AngW-1:0]       s2_wrapped;
  prac_pkg::geom_t                        s2_geom;
  logic signed [prac_pkg::AngW-1:0]       sa;
  logic                                   neg_w;
  prac_pkg::rot_t                         rot_next;

  always_comb begin
    geom_next.cx = prac_pkg::CenterW'(center_x_base) + prac_pkg::CenterW'(offset_x);
    geom_next.cy = prac_pkg::CenterW'(center_y_base) + prac_pkg::CenterW'(offset_y);
    geom_next.dx = prac_pkg::DiffW'(point_x) - prac_pkg::DiffW'(geom_next.cx);
    geom_next.dy = prac_pkg::DiffW'(point_y) - prac_pkg::DiffW'(geom_next.cy);
  end

  always_ff @(posedge clk) begin
    s1_prod <= prac_pkg::AProdW'(angle_deg) * prac_pkg::AProdW'(angle_ratio);
    s1_geom <= geom_next;
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  always_comb begin
    rnd     = s1_prod + prac_pkg::AProdW'(8192);
    eff     = rnd[prac_pkg::AProdW-1:14];
    ubias   = prac_pkg::EffW'(eff) + prac_pkg::EffW'(prac_pkg::WrapBias);
    wrapped = ubias;
    for (int m = 1; m <= prac_pkg::WrapSteps; m++) begin
      if (ubias >= prac_pkg::EffW'(m * prac_pkg::UnitsFull)) begin
        wrapped = ubias - prac_pkg::EffW'(m * prac_pkg::UnitsFull);
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_wrapped <= signed'(prac_pkg::AngW'(wrapped));
    s2_geom    <= s1_geom;
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_comb begin
    sa    = s2_wrapped;
    neg_w = 1'b0;
    if (sa > prac_pkg::AngW'(prac_pkg::UnitsHalf)) begin
      sa = sa - prac_pkg::AngW'(prac_pkg::UnitsFull);
    end
    if (sa > prac_pkg::AngW'(prac_pkg::UnitsQuarter)) begin
      sa    = sa - prac_pkg::AngW'(prac_pkg::UnitsHalf);
      neg_w = 1'b1;
    end else if (sa < -prac_pkg::AngW'(prac_pkg::UnitsQuarter)) begin
      sa    = sa + prac_pkg::AngW'(prac_pkg::UnitsHalf);
      neg_w = 1'b1;
    end
    rot_next.valid = s2_valid;
    rot_next.neg   = neg_w;
    rot_next.x     = prac_pkg::CsW'(prac_pkg::GainQ30);
    rot_next.y     = '0;
    rot_next.z     = prac_pkg::ZW'(sa) <<< 10;
    rot_next.geom  = s2_geom;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_out.valid <= 1'b0;
    end else begin
      rot_out <= rot_next;
    end
  end

endmodule

@@ design/prac_cordic_stage.sv @@
`timescale 1ns / 1ps
// One registered rotation-mode CORDIC iteration.
module prac_cordic_stage (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [prac_pkg::StageW-1:0]       stage,
  input  prac_pkg::rot_t                    rot_in,
  output prac_pkg::rot_t                    rot_out
);

  logic signed [prac_pkg::CsW-1:0] tx;
  logic signed [prac_pkg::CsW-1:0] ty;
  logic signed [prac_pkg::ZW-1:0]  at;
  prac_pkg::rot_t                  rot_next;

  always_comb begin
    tx       = rot_in.y >>> stage;
    ty       = rot_in.x >>> stage;
    at       = prac_pkg::atan_q16(stage);
    rot_next = rot_in;
    if (!rot_in.z[prac_pkg::ZW-1]) begin
      rot_next.x = rot_in.x - tx;
      rot_next.y = rot_in.y + ty;
      rot_next.z = rot_in.z - at;
    end else begin
      rot_next.x = rot_in.x + tx;
      rot_next.y = rot_in.y - ty;
      rot_next.z = rot_in.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_out.valid <= 1'b0;
    end else begin
      rot_out <= rot_next;
    end
  end

endmodule

@@ design/prac_xform.sv @@
`timescale 1ns / 1ps
// Back end: sign fix, rotation products, rounding, recentering and saturation.
module prac_xform (
  input  logic                                     clk,
  input  logic                                     rst,
  input  prac_pkg::rot_t                           rot_in,
  output logic                                     done,
  output logic signed [prac_pkg::CoordWidth-1:0]   rotated_x,
  output logic signed [prac_pkg::CoordWidth-1:0]   rotated_y,
  output logic                                     clipped
);

  logic signed [prac_pkg::CsW-1:0]     cs;
  logic signed [prac_pkg::CsW-1:0]     sn;
  logic                                m_valid;
  logic signed [prac_pkg::ProdW-1:0]   p_xc;
  logic signed [prac_pkg::ProdW-1:0]   p_ys;
  logic signed [prac_pkg::ProdW-1:0]   p_xs;
  logic signed [prac_pkg::ProdW-1:0]   p_yc;
  logic signed [prac_pkg::CenterW-1:0] m_cx;
  logic signed [prac_pkg::CenterW-1:0] m_cy;

  logic signed [prac_pkg::ProdW:0]     sx;
  logic signed [prac_pkg::ProdW:0]     sy;
  logic signed [prac_pkg::RotW-1:0]    rx;
  logic signed [prac_pkg::RotW-1:0]    ry;
  logic signed [prac_pkg::SumW-1:0]    ox;
  logic signed [prac_pkg::SumW-1:0]    oy;
  logic signed [prac_pkg::CoordWidth-1:0] rotated_x_next;
  logic signed [prac_pkg::CoordWidth-1:0] rotated_y_next;
  logic                                clip_x;
  logic                                clip_y;

  always_comb begin
    cs = rot_in.neg ? -rot_in.x : rot_in.x;
    sn = rot_in.neg ? -rot_in.y : rot_in.y;
  end

  always_ff @(posedge clk) begin
    p_xc <= prac_pkg::ProdW'(rot_in.geom.dx) * prac_pkg::ProdW'(cs);
    p_ys <= prac_pkg::ProdW'(rot_in.geom.dy) * prac_pkg::ProdW'(sn);
    p_xs <= prac_pkg::ProdW'(rot_in.geom.dx) * prac_pkg::ProdW'(sn);
    p_yc <= prac_pkg::ProdW'(rot_in.geom.dy) * prac_pkg::ProdW'(cs);
    m_cx <= rot_in.geom.cx;
    m_cy <= rot_in.geom.cy;
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= rot_in.valid;
    end
  end

  always_comb begin
    sx = (prac_pkg::ProdW + 1)'(p_xc) - (prac_pkg::ProdW + 1)'(p_ys)
         + (prac_pkg::ProdW + 1)'(64'sd536870912);
    sy = (prac_pkg::ProdW + 1)'(p_xs) + (prac_pkg::ProdW + 1)'(p_yc)
         + (prac_pkg::ProdW + 1)'(64'sd536870912);
    rx = sx[prac_pkg::ProdW:30];
    ry = sy[prac_pkg::ProdW:30];
    ox = prac_pkg::SumW'(m_cx) + prac_pkg::SumW'(rx);
    oy = prac_pkg::SumW'(m_cy) + prac_pkg::SumW'(ry);
    clip_x = 1'b1;
    clip_y = 1'b1;
    if (ox > prac_pkg::SumW'(prac_pkg::CoordMax)) begin
      rotated_x_next = prac_pkg::CoordMax;
    end else if (ox < prac_pkg::SumW'(prac_pkg::CoordMin)) begin
      rotated_x_next = prac_pkg::CoordMin;
    end else begin
      rotated_x_next = ox[prac_pkg::CoordWidth-1:0];
      clip_x         = 1'b0;
    end
    if (oy > prac_pkg::SumW'(prac_pkg::CoordMax)) begin
      rotated_y_next = prac_pkg::CoordMax;
    end else if (oy < prac_pkg::SumW'(prac_pkg::CoordMin)) begin
      rotated_y_next = prac_pkg::CoordMin;
    end else begin
      rotated_y_next = oy[prac_pkg::CoordWidth-1:0];
      clip_y         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rotated_x <= rotated_x_next;
    rotated_y <= rotated_y_next;
    clipped   <= clip_x | clip_y;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_valid;
    end
  end

endmodule

@@ design/point_rotate_about_center_unit.sv @@
`timescale 1ns / 1ps
// Top level of the point rotation unit: rotates each point about a shifted center.
// Throughput: one request per cycle; busy stays low, so no request waits.
// The 14 CORDIC iterations each take one register stage; angle and product work take five.
// Synchronous reset clears the pipeline valid bits and the three config registers to 0.
module point_rotate_about_center_unit (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  output logic                                     busy,
  input  logic signed [prac_pkg::PosW-1:0]         point_x,
  input  logic signed [prac_pkg::PosW-1:0]         point_y,
  input  logic signed [prac_pkg::RatioW-1:0]       angle_ratio,
  input  logic signed [prac_pkg::PosW-1:0]         offset_x,
  input  logic signed [prac_pkg::PosW-1:0]         offset_y,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [1:0]                               cfg_index,
  input  logic [prac_pkg::AngW-1:0]                cfg_data,
  output logic                                     done,
  output logic signed [prac_pkg::CoordWidth-1:0]   rotated_x,
  output logic signed [prac_pkg::CoordWidth-1:0]   rotated_y,
  output logic                                     clipped
);

  logic signed [prac_pkg::AngW-1:0] angle_deg;
  logic signed [prac_pkg::PosW-1:0] center_x_base;
  logic signed [prac_pkg::PosW-1:0] center_y_base;
  logic                             accept;
  prac_pkg::rot_t                   chain [prac_pkg::CordicStages+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_deg     <= '0;
      center_x_base <= '0;
      center_y_base <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        prac_pkg::RegAngle:   angle_deg     <= cfg_data;
        prac_pkg::RegCenterX: center_x_base <= cfg_data[prac_pkg::PosW-1:0];
        prac_pkg::RegCenterY: center_y_base <= cfg_data[prac_pkg::PosW-1:0];
        default: ;
      endcase
    end
  end

  prac_angle u_angle (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (accept),
    .angle_deg     (angle_deg),
    .center_x_base (center_x_base),
    .center_y_base (center_y_base),
    .point_x       (point_x),
    .point_y       (point_y),
    .angle_ratio   (angle_ratio),
    .offset_x      (offset_x),
    .offset_y      (offset_y),
    .rot_out       (chain[0])
  );

  for (genvar i = 0; i < prac_pkg::CordicStages; i++) begin : g_cordic
    prac_cordic_stage u_stage (
      .clk     (clk),
      .rst     (rst),
      .stage   (prac_pkg::StageW'(i)),
      .rot_in  (chain[i]),
      .rot_out (chain[i+1])
    );
  end

  prac_xform u_xform (
    .clk       (clk),
    .rst       (rst),
    .rot_in    (chain[prac_pkg::CordicStages]),
    .done      (done),
    .rotated_x (rotated_x),
    .rotated_y (rotated_y),
    .clipped   (clipped)
  );

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(prac_pkg::Latency) done)
    else $error("request did not produce a result after the pipeline latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, prac_pkg::Latency))
    else $error("result strobe without a matching request");

  a_clip_value: assert property (@(posedge clk) disable iff (rst)
    done && clipped |-> (rotated_x == prac_pkg::CoordMax || rotated_x == prac_pkg::CoordMin ||
                         rotated_y == prac_pkg::CoordMax || rotated_y == prac_pkg::CoordMin))
    else $error("clipped flag set without a saturated coordinate");
`endif

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the point rotation unit: directed and random points against a CORDIC predictor.

typedef struct packed {
  logic signed [prac_pkg::CoordWidth-1:0] x;
  logic signed [prac_pkg::CoordWidth-1:0] y;
  logic                                   clip;
} rotated_point_t;

class rotation_scoreboard;
  longint         angle_reg;
  longint         center_x_reg;
  longint         center_y_reg;
  rotated_point_t pending_points[$];
  int             errors;

  function new();
    angle_reg    = 0;
    center_x_reg = 0;
    center_y_reg = 0;
    errors       = 0;
  endfunction

  function void apply_register(logic [1:0] index, logic [prac_pkg::AngW-1:0] data);
    logic signed [prac_pkg::AngW-1:0] ang;
    logic signed [prac_pkg::PosW-1:0] ctr;
    ang = data;
    ctr = data[prac_pkg::PosW-1:0];
    case (index)
      prac_pkg::RegAngle:   angle_reg = longint'(ang);
      prac_pkg::RegCenterX: center_x_reg = longint'(ctr);
      prac_pkg::RegCenterY: center_y_reg = longint'(ctr);
      default: ;
    endcase
  endfunction

  function longint clamp_coord(longint v, inout logic clip);
    longint hi;
    longint lo;
    hi = (longint'(1) << (prac_pkg::CoordWidth - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      clip = 1'b1;
      return hi;
    end
    if (v < lo) begin
      clip = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function rotated_point_t rotate_point(longint px, longint py, longint ratio,
                                        longint ox, longint oy);
    longint         arctan_q16 [0:23];
    longint         eff;
    longint         a;
    longint         z;
    longint         cs;
    longint         sn;
    longint         tx;
    longint         ty;
    longint         cx;
    longint         cy;
    longint         dx;
    longint         dy;
    logic           neg;
    logic           clip;
    rotated_point_t r;
    arctan_q16 = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                   14668, 7334, 3667, 1833, 917, 458, 229, 115,
                   57, 29, 14, 7, 4, 2, 1, 0};
    eff = (angle_reg * ratio + 8192) >>> 14;
    a = ((eff % prac_pkg::UnitsFull) + prac_pkg::UnitsFull) % prac_pkg::UnitsFull;
    neg = 1'b0;
    if (a > prac_pkg::UnitsHalf) a = a - prac_pkg::UnitsFull;
    if (a > prac_pkg::UnitsQuarter) begin
      a = a - prac_pkg::UnitsHalf;
      neg = 1'b1;
    end else if (a < -prac_pkg::UnitsQuarter) begin
      a = a + prac_pkg::UnitsHalf;
      neg = 1'b1;
    end
    z  = a * 1024;
    cs = longint'(prac_pkg::GainQ30);
    sn = 0;
    for (int i = 0; i < prac_pkg::CordicStages && i < 24; i++) begin
      tx = sn >>> i;
      ty = cs >>> i;
      if (z >= 0) begin
        cs = cs - tx;
        sn = sn + ty;
        z  = z - arctan_q16[i];
      end else begin
        cs = cs + tx;
        sn = sn - ty;
        z  = z + arctan_q16[i];
      end
    end
    if (neg) begin
      cs = -cs;
      sn = -sn;
    end
    cx = center_x_reg + ox;
    cy = center_y_reg + oy;
    dx = px - cx;
    dy = py - cy;
    clip = 1'b0;
    r.x = prac_pkg::CoordWidth'(clamp_coord(cx + ((dx * cs - dy * sn + 536870912) >>> 30),
                                            clip));
    r.y = prac_pkg::CoordWidth'(clamp_coord(cy + ((dx * sn + dy * cs + 536870912) >>> 30),
                                            clip));
    r.clip = clip;
    return r;
  endfunction

  function void note_request(longint px, longint py, longint ratio, longint ox, longint oy);
    pending_points.push_back(rotate_point(px, py, ratio, ox, oy));
  endfunction

  function void check_result(logic signed [prac_pkg::CoordWidth-1:0] rx,
                             logic signed [prac_pkg::CoordWidth-1:0] ry, logic clip);
    rotated_point_t want;
    if (pending_points.size() == 0) begin
      $display("%0t: unexpected result x=%0d y=%0d clipped=%0d", $time, rx, ry, clip);
      errors++;
      return;
    end
    want = pending_points.pop_front();
    if (rx !== want.x) begin
      $display("%0t: rotated_x expected %0d actual %0d", $time, want.x, rx);
      errors++;
    end
    if (ry !== want.y) begin
      $display("%0t: rotated_y expected %0d actual %0d", $time, want.y, ry);
      errors++;
    end
    if (clip !== want.clip) begin
      $display("%0t: clipped expected %0d actual %0d", $time, want.clip, clip);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int         CycleLimit  = 200000;
  localparam int         Drain       = prac_pkg::Latency + 8;
  localparam int         PhaseItems  = 171;
  localparam int         MaxGap      = 40;
  localparam logic [1:0] RegUnused   = 2'd3;

  logic                                   clk;
  logic                                   rst;
  logic                                   start;
  logic                                   busy;
  logic signed [prac_pkg::PosW-1:0]       point_x;
  logic signed [prac_pkg::PosW-1:0]       point_y;
  logic signed [prac_pkg::RatioW-1:0]     angle_ratio;
  logic signed [prac_pkg::PosW-1:0]       offset_x;
  logic signed [prac_pkg::PosW-1:0]       offset_y;
  logic                                   cfg_valid;
  logic                                   cfg_ready;
  logic [1:0]                             cfg_index;
  logic [prac_pkg::AngW-1:0]              cfg_data;
  logic                                   done;
  logic signed [prac_pkg::CoordWidth-1:0] rotated_x;
  logic signed [prac_pkg::CoordWidth-1:0] rotated_y;
  logic                                   clipped;

  rotation_scoreboard board;
  int                 idle_pct;
  longint             cycle_count;

  point_rotate_about_center_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .point_x(point_x),
    .point_y(point_y),
    .angle_ratio(angle_ratio),
    .offset_x(offset_x),
    .offset_y(offset_y),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .rotated_x(rotated_x),
    .rotated_y(rotated_y),
    .clipped(clipped)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) board.apply_register(cfg_index, cfg_data);
      if (start && !busy) begin
        board.note_request(longint'(point_x), longint'(point_y), longint'(angle_ratio),
                           longint'(offset_x), longint'(offset_y));
      end
      if (done) board.check_result(rotated_x, rotated_y, clipped);
    end
  end

  function automatic int random_pos();
    if ($urandom_range(9) == 0) return int'($urandom);
    return int'($urandom_range(16384)) - 8192;
  endfunction

  function automatic int random_ratio();
    if ($urandom_range(9) == 0) return int'($urandom);
    return int'($urandom_range(32768)) - 16384;
  endfunction

  function automatic int pick_gap();
    int gap;
    gap = 0;
    while (gap < MaxGap && $urandom_range(99) < idle_pct) gap++;
    return gap;
  endfunction

  task automatic send_point(input int px, input int py, input int ratio,
                            input int ox, input int oy, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    point_x     = prac_pkg::PosW'(px);
    point_y     = prac_pkg::PosW'(py);
    angle_ratio = prac_pkg::RatioW'(ratio);
    offset_x    = prac_pkg::PosW'(ox);
    offset_y    = prac_pkg::PosW'(oy);
    start       = 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_points();
    @(negedge clk);
    start = 1'b0;
    while (board.pending_points.size() != 0) @(posedge clk);
  endtask

  task automatic program_register(input logic [1:0] index, input int data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = prac_pkg::AngW'(data);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic program_setting(input int ang, input int cx, input int cy);
    drain_points();
    program_register(prac_pkg::RegAngle, ang);
    program_register(prac_pkg::RegCenterX, cx);
    program_register(prac_pkg::RegCenterY, cy);
    program_register(RegUnused, int'($urandom));
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    board       = new();
    clk         = 1'b0;
    rst         = 1'b1;
    start       = 1'b0;
    point_x     = '0;
    point_y     = '0;
    angle_ratio = '0;
    offset_x    = '0;
    offset_y    = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    idle_pct    = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_point(8192, -8192, 16384, 8192, -8192, 0);
    send_point(-16384, 16383, -32768, -16384, 16383, 0);

    program_setting(23040, 8192, -8192);
    send_point(8192, 8192, 16384, 0, 0, 0);
    send_point(-8192, -8192, 4096, 8192, -8192, 0);
    send_point(16383, -16384, 8192, -8192, 8192, 0);
    send_point(0, 0, 12288, 0, 0, 0);
    send_point(8192, -8192, -16384, -8192, -8192, 0);
    send_point(-8192, 8192, 2048, 8192, 8192, 0);
    send_point(-16384, 0, 8192, 8192, 0, 0);
    send_point(16383, 16383, 32767, -16384, -16384, 0);
    send_point(-16384, -16384, -32768, 16383, 16383, 0);
    send_point(4096, -4096, 0, 0, 0, 0);
    send_point(8192, 0, 16, 0, 0, 0);
    send_point(8192, 0, -16, 0, 0, 0);
    send_point(-16384, 16383, 2048, 16383, -16384, 0);
    send_point(16383, -16384, -2048, -16384, 16383, 0);
    send_point(0, -16384, 8192, 0, 16383, 0);
    send_point(-1, -1, -1, -1, -1, 0);
    send_point(1, 1, 1, 1, 1, 0);
    send_point(8192, 8192, -4096, -8192, -8192, 0);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: program_setting(-23040, -8192, 8192);
        1: program_setting(int'($urandom_range(46080)) - 23040,
                           int'($urandom_range(16384)) - 8192,
                           int'($urandom_range(16384)) - 8192);
        2: program_setting(32767, 'hbfff, 'h4000);
        3: program_setting('h8000, int'($urandom), int'($urandom));
        4: program_setting(5760, int'($urandom_range(16384)) - 8192,
                           int'($urandom_range(16384)) - 8192);
        default: program_setting(int'($urandom), 8192, -8192);
      endcase
      case (phase % 3)
        0: idle_pct = 0;
        1: idle_pct = 55;
        default: idle_pct = 20;
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        send_point(random_pos(), random_pos(), random_ratio(), random_pos(), random_pos(),
                   pick_gap());
      end
    end

    drain_points();
    repeat (Drain) @(posedge clk);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
